// ===== src/binomial_mod_prime_assert.svh =====
// Assertion macros for the binomial_mod_prime checker.
// No dependencies; included by the checker file.
`ifndef BINOMIAL_MOD_PRIME_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define BMP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bmp_pkg.sv =====
// Shared constants and types for the binomial mod prime block.
// No dependencies.
package bmp_pkg;

  localparam int PRIME_W    = 30;
  localparam int TABLE_SIZE = 4096;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int MM_LAT     = 5;

  localparam logic [PRIME_W-1:0] PRIME = 30'd1000000007;
  localparam logic [PRIME_W-1:0] EXPO  = PRIME - 30'd2;
  localparam logic [63:0]        MU_W  = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0]        MU    = MU_W[30:0];

  typedef logic [PRIME_W-1:0] mword_t;

endpackage

// ===== src/bmp_modmul.sv =====
// Pipelined modular multiplier, Barrett reduction, five register stages.
// Depends on bmp_pkg.
module bmp_modmul import bmp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  mword_t a,
  input  mword_t b,
  output logic   out_valid,
  output mword_t y
);

  logic [MM_LAT-1:0] v_r;
  logic [59:0]       prod_r;
  logic [61:0]       t_r;
  logic [31:0]       xl2_r, xl3_r, qp_r, rem_r;
  mword_t            y_r;
  logic [31:0]       rem_p1, rem_p2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[MM_LAT-2:0], in_valid};
    end
  end

  assign rem_p1 = rem_r - {2'b0, PRIME};
  assign rem_p2 = rem_r - {1'b0, PRIME, 1'b0};

  always_ff @(posedge clk) begin
    prod_r <= 60'(a) * 60'(b);
    t_r    <= 62'(prod_r[59:29]) * 62'(MU);
    xl2_r  <= prod_r[31:0];
    qp_r   <= 32'(t_r[61:31]) * 32'(PRIME);
    xl3_r  <= xl2_r;
    rem_r  <= xl3_r - qp_r;
    // quotient estimate is short by at most two
    if (rem_r >= {1'b0, PRIME, 1'b0}) begin
      y_r <= rem_p2[PRIME_W-1:0];
    end else if (rem_r >= {2'b0, PRIME}) begin
      y_r <= rem_p1[PRIME_W-1:0];
    end else begin
      y_r <= rem_r[PRIME_W-1:0];
    end
  end

  assign out_valid = v_r[MM_LAT-1];
  assign y         = y_r;

endmodule

// ===== src/binomial_mod_prime.sv =====
// binomial_mod_prime: C(n,r) mod 1000000007 from factorial and inverse-factorial RAMs.
// Throughput one item per cycle, held off while 16 items are in flight or held in the FIFO.
// Queries flow through the two chained five-stage modular multipliers into a 16-entry FIFO.
// Reset (rst_n low, synchronous) starts a table build: the factorial walk upward, a
// Fermat exponentiation of the top factorial and the inverse walk downward, during
// which in_tready stays low.
module binomial_mod_prime import bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] n_total, [23:12] r_chosen
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] binomial, [31:30] zero
);

  localparam logic [1:0] ST_FACT = 2'd0;
  localparam logic [1:0] ST_POW  = 2'd1;
  localparam logic [1:0] ST_INV  = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  localparam int FIFO_DEPTH = 16;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_SIZE - 1);

  // table storage
  mword_t fact_mem [TABLE_SIZE];
  mword_t inv_mem  [TABLE_SIZE];

  // build sequencer
  logic [1:0]       st_r, st_nxt;
  logic             wait_r, wait_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  mword_t           acc_r, acc_nxt;
  mword_t           base_r, base_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic             mul_r, mul_nxt;
  logic             build_issue;

  // multipliers
  mword_t ma_a, ma_b, ma_y, mb_y;
  logic   ma_v, ma_ov, mb_v, mb_ov;

  // query pipeline
  logic [11:0]       q_n, q_r;
  logic [IDX_W-1:0]  q_diff;
  logic              q_zero;
  logic              in_acc, out_acc;
  mword_t            f_rd_r, ir_rd_r, inr_rd_r;
  logic              q1_v_r, q1_zero_r;
  mword_t            inr_d_r  [MM_LAT];
  logic [2*MM_LAT-1:0] zero_d_r;

  // output FIFO
  mword_t            fifo_mem [FIFO_DEPTH];
  logic [FPTR_W:0]   wr_ptr_r, rd_ptr_r;
  logic [FPTR_W:0]   cnt_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (st_r == ST_RUN) && (cnt_r < (FPTR_W+1)'(FIFO_DEPTH));

  // ---------------- build sequencer ----------------
  always_comb begin
    build_issue = 1'b0;
    if (!wait_r) begin
      case (st_r)
        ST_FACT: build_issue = (idx_r != IDX_TOP);
        ST_POW:  build_issue = 1'b1;
        ST_INV:  build_issue = (idx_r != '0);
        default: build_issue = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt   = st_r;
    wait_nxt = wait_r;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    bit_nxt  = bit_r;
    mul_nxt  = mul_r;
    case (st_r)
      ST_FACT: begin
        if (!wait_r) begin
          if (idx_r == IDX_TOP) begin
            // start exponentiation of the top factorial
            st_nxt   = ST_POW;
            base_nxt = acc_r;
            acc_nxt  = 30'd1;
            bit_nxt  = 5'(PRIME_W - 1);
            mul_nxt  = 1'b0;
          end else begin
            wait_nxt = 1'b1;
          end
        end else if (ma_ov) begin
          acc_nxt  = ma_y;
          idx_nxt  = idx_r + 1'b1;
          wait_nxt = 1'b0;
        end
      end
      ST_POW: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ma_ov) begin
          acc_nxt  = ma_y;
          wait_nxt = 1'b0;
          if (!mul_r && EXPO[bit_r]) begin
            mul_nxt = 1'b1;
          end else begin
            mul_nxt = 1'b0;
            if (bit_r == '0) begin
              st_nxt  = ST_INV;
              idx_nxt = IDX_TOP;
            end else begin
              bit_nxt = bit_r - 1'b1;
            end
          end
        end
      end
      ST_INV: begin
        if (!wait_r) begin
          if (idx_r == '0) begin
            st_nxt = ST_RUN;
          end else begin
            wait_nxt = 1'b1;
          end
        end else if (ma_ov) begin
          acc_nxt  = ma_y;
          idx_nxt  = idx_r - 1'b1;
          wait_nxt = 1'b0;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_FACT;
      wait_r <= 1'b0;
      idx_r  <= '0;
      acc_r  <= 30'd1;
      base_r <= 30'd1;
      bit_r  <= '0;
      mul_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
      idx_r  <= idx_nxt;
      acc_r  <= acc_nxt;
      base_r <= base_nxt;
      bit_r  <= bit_nxt;
      mul_r  <= mul_nxt;
    end
  end

  // first multiplier: build operands while filling, query operands once running
  always_comb begin
    if (st_r == ST_RUN) begin
      ma_a = f_rd_r;
      ma_b = ir_rd_r;
      ma_v = q1_v_r;
    end else begin
      ma_a = acc_r;
      ma_v = build_issue;
      case (st_r)
        ST_FACT: ma_b = PRIME_W'(idx_r) + 30'd1;
        ST_POW:  ma_b = mul_r ? base_r : acc_r;
        default: ma_b = PRIME_W'(idx_r);
      endcase
    end
  end

  bmp_modmul u_mul_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ma_v),
    .a         (ma_a),
    .b         (ma_b),
    .out_valid (ma_ov),
    .y         (ma_y)
  );

  // second multiplier takes only query products
  assign mb_v = ma_ov && (st_r == ST_RUN);

  bmp_modmul u_mul_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mb_v),
    .a         (ma_y),
    .b         (inr_d_r[MM_LAT-1]),
    .out_valid (mb_ov),
    .y         (mb_y)
  );

  // ---------------- table memories ----------------
  assign q_n    = in_tdata[11:0];
  assign q_r    = in_tdata[23:12];
  assign q_diff = IDX_W'(q_n - q_r);
  assign q_zero = (q_r > q_n) || (32'(q_n) >= TABLE_SIZE);

  always_ff @(posedge clk) begin
    if ((st_r == ST_FACT) && !wait_r) begin
      fact_mem[idx_r] <= acc_r;
    end
    f_rd_r <= fact_mem[IDX_W'(q_n)];
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_INV) && !wait_r) begin
      inv_mem[idx_r] <= acc_r;
    end
    ir_rd_r  <= inv_mem[IDX_W'(q_r)];
    inr_rd_r <= inv_mem[q_diff];
  end

  // ---------------- query control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
    end else begin
      q1_v_r <= in_acc;
    end
  end

  // align inverse of (n-r) and the zero flag with the multiplier outputs
  always_ff @(posedge clk) begin
    q1_zero_r  <= q_zero;
    inr_d_r[0] <= inr_rd_r;
    for (int i = 1; i < MM_LAT; i++) begin
      inr_d_r[i] <= inr_d_r[i-1];
    end
    zero_d_r <= {zero_d_r[2*MM_LAT-2:0], q1_zero_r};
  end

  // ---------------- output FIFO ----------------
  always_ff @(posedge clk) begin
    if (mb_ov) begin
      fifo_mem[wr_ptr_r[FPTR_W-1:0]] <= zero_d_r[2*MM_LAT-1] ? '0 : mb_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (mb_ov) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      // count items in flight plus items held
      if (in_acc && !out_acc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!in_acc && out_acc) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign out_tvalid = (wr_ptr_r != rd_ptr_r);
  assign out_tdata  = {2'b00, fifo_mem[rd_ptr_r[FPTR_W-1:0]]};

endmodule

// ===== src/bmp_checker.sv =====
// Port-level checker for binomial_mod_prime, bound to the top level.
// Depends on bmp_pkg and binomial_mod_prime_assert.svh.
`include "binomial_mod_prime_assert.svh"

module bmp_checker import bmp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `BMP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result item dropped")
  `BMP_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `BMP_ASSERT_NOW(a_out_range, out_tvalid, out_tdata < {2'b00, PRIME}, "result not reduced")
  `BMP_ASSERT_NEXT_ALWAYS(a_build_after_reset, !rst_n, !in_tready && !out_tvalid, "ready in build")

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/testbench.sv =====
// Testbench for binomial_mod_prime: drives n/r queries on the input stream and checks
// each C(n,r) mod p result against an in-bench factorial-table predictor.
// Depends on bmp_pkg and the binomial_mod_prime RTL.
module testbench;
  import bmp_pkg::*;

  localparam longint unsigned MODULUS = 64'd1000000007;
  localparam int LATENCY = 11;
  localparam int STALL_LIMIT = 200000;  // covers the table build after reset

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [11:0] n_total, [23:12] r_chosen
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [29:0] binomial, [31:30] zero

  mword_t fact_tbl [TABLE_SIZE];
  mword_t inv_fact_tbl [TABLE_SIZE];
  mword_t expected_binomials [$];
  bit     failed = 1'b0;
  bit     quiet;           // no idling in the last part of the run
  int     idle_cycles = 0;

  binomial_mod_prime dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic mword_t mod_mul(mword_t a, mword_t b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return mword_t'(prod % MODULUS);
  endfunction

  // Build factorials upward, then inverse factorials downward from one Fermat power.
  function automatic void build_factorials();
    mword_t acc;
    mword_t base;
    int unsigned ex;
    fact_tbl[0] = 30'd1;
    for (int i = 1; i < TABLE_SIZE; i++) fact_tbl[i] = mod_mul(fact_tbl[i-1], mword_t'(i));
    acc = 30'd1;
    base = fact_tbl[TABLE_SIZE-1];
    ex = 32'd1000000005;
    while (ex != 0) begin
      if (ex[0]) acc = mod_mul(acc, base);
      base = mod_mul(base, base);
      ex = ex >> 1;
    end
    inv_fact_tbl[TABLE_SIZE-1] = acc;
    for (int i = TABLE_SIZE-1; i > 0; i--) inv_fact_tbl[i-1] = mod_mul(inv_fact_tbl[i], mword_t'(i));
  endfunction

  function automatic mword_t predict_binomial(logic [11:0] n, logic [11:0] r);
    if (r > n || n >= TABLE_SIZE) return '0;
    return mod_mul(mod_mul(fact_tbl[n], inv_fact_tbl[r]), inv_fact_tbl[n-r]);
  endfunction

  // Send one query, with an optional random idle burst ahead of it.
  task automatic send_query(logic [11:0] n, logic [11:0] r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_binomials.insert(expected_binomials.size(), predict_binomial(n, r));
  endtask

  // Check each result as it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_binomials.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
        failed = 1'b1;
      end else begin
        if (out_tdata !== {2'b00, expected_binomials[0]}) begin
          $display("%0t: binomial mismatch, expected %0d, actual %0d", $time,
                   expected_binomials[0], out_tdata);
          failed = 1'b1;
        end
        void'(expected_binomials.pop_front());
      end
    end
  end

  // Random receiver stalls in bursts.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_tready  <= (idle_cycles == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      idle_cycles <= int'($urandom_range(1, 14));
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles without any accepted item.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("binomial_mod_prime verification failed");
      $finish;
    end
  end

  task automatic test_edges();
    send_query(12'd0, 12'd0);
    send_query(12'd4095, 12'd0);
    send_query(12'd4095, 12'd4095);
    send_query(12'd4095, 12'd2047);
    send_query(12'd4095, 12'd1);
    send_query(12'd1, 12'd1);
    send_query(12'd10, 12'd3);
    send_query(12'd2048, 12'd1024);
    send_query(12'd2730, 12'd1365);
  endtask

  task automatic test_r_exceeds_n();
    send_query(12'd0, 12'd4095);
    send_query(12'd0, 12'd1);
    send_query(12'd4094, 12'd4095);
    send_query(12'd5, 12'd6);
    send_query(12'd1365, 12'd2730);
  endtask

  // Mostly r <= n so the nonzero path dominates; bit patterns span both values.
  task automatic test_random(int count);
    logic [11:0] n, r;
    for (int i = 0; i < count; i++) begin
      n = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 4) == 0) r = 12'($urandom_range(0, 4095));
      else r = 12'($urandom_range(0, n));
      send_query(n, r);
    end
  endtask

  initial begin
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    build_factorials();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_r_exceeds_n();
    test_random(1000);
    quiet = 1'b1;
    test_random(200);
    in_tvalid <= 1'b0;
    while (expected_binomials.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (!failed) begin
      $display("binomial_mod_prime verification clean");
    end else begin
      $display("binomial_mod_prime verification failed");
    end
    $finish;
  end
endmodule
